/* src/tvpt_pkg.sv */
package tvpt_pkg;

    // Register file geometry
    localparam int REG_W    = 64;
    localparam int NUM_REGS = 5;
    localparam int IDX_W    = 3;

    // Default widths handed to the top level
    localparam int PIX_W_DEF  = 12;
    localparam int COEF_W_DEF = 16;
    localparam int OUT_W_DEF  = 24;

    // Fraction bits of the output
    localparam int FRAC_W = 4;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CAM1_ROW0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_CAM1_ROW1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_CAM1_ROW2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_CAM2_ROW0 = 3'd3;
    localparam logic [IDX_W-1:0] REG_CAM2_ROW2 = 3'd4;

    // Latency of the determinant pipeline
    localparam int DET_LAT = 5;

endpackage

/* src/tvpt_det3.sv */
module tvpt_det3 #(
    parameter int AW = 29
) (
    input  logic                    clk,
    input  logic signed [AW-1:0]    m [3][3],
    output logic signed [3*AW+2:0]  det
);
    localparam int MW = 2 * AW + 1;
    localparam int LW = AW;
    localparam int PW = 3 * AW + 1;
    localparam int DW = 3 * AW + 3;

    logic signed [2*AW-1:0] pr_reg [6];
    logic signed [AW-1:0]   r0_reg [3];
    logic signed [MW-1:0]   mn_reg [3];
    logic signed [AW-1:0]   r0d_reg [3];
    logic signed [2*AW:0]   pl_reg [3];
    logic signed [2*AW:0]   ph_reg [3];
    logic signed [PW-1:0]   pf_reg [3];
    logic signed [DW-1:0]   det_reg;

    // Products of the lower two rows.
    always_ff @(posedge clk)
    begin
        pr_reg[0] <= m[1][1] * m[2][2];
        pr_reg[1] <= m[1][2] * m[2][1];
        pr_reg[2] <= m[1][0] * m[2][2];
        pr_reg[3] <= m[1][2] * m[2][0];
        pr_reg[4] <= m[1][0] * m[2][1];
        pr_reg[5] <= m[1][1] * m[2][0];
        for (int c = 0; c < 3; c++)
        begin
            r0_reg[c] <= m[0][c];
        end
    end

    // Cofactors; the middle one carries its negative sign.
    always_ff @(posedge clk)
    begin
        mn_reg[0] <= MW'(pr_reg[0]) - MW'(pr_reg[1]);
        mn_reg[1] <= MW'(pr_reg[3]) - MW'(pr_reg[2]);
        mn_reg[2] <= MW'(pr_reg[4]) - MW'(pr_reg[5]);
        r0d_reg   <= r0_reg;
    end

    // Top row times each cofactor, split into a low and a high partial product.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            pl_reg[c] <= r0d_reg[c] * $signed({1'b0, mn_reg[c][LW-1:0]});
            ph_reg[c] <= r0d_reg[c] * $signed(mn_reg[c][MW-1:LW]);
        end
    end

    // Recombine the partial products.
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            pf_reg[c] <= (PW'(ph_reg[c]) <<< LW) + PW'(pl_reg[c]);
        end
    end

    // Sum of the three terms.
    always_ff @(posedge clk)
    begin
        det_reg <= DW'(pf_reg[0]) + DW'(pf_reg[1]) + DW'(pf_reg[2]);
    end

    assign det = det_reg;

endmodule

/* src/tvpt_div.sv */
module tvpt_div #(
    parameter int DW    = 90,
    parameter int OUT_W = 24
) (
    input  logic                    clk,
    input  logic signed [DW-1:0]    num,
    input  logic signed [DW-1:0]    den,
    output logic signed [OUT_W-1:0] quo,
    output logic                    clip
);
    import tvpt_pkg::*;

    localparam int RW = DW + OUT_W + FRAC_W + 2;
    localparam logic [OUT_W:0] LIM = (OUT_W + 1)'(1) << (OUT_W - 1);

    logic [DW-1:0] an;
    logic [DW-1:0] ad;

    logic [RW-1:0] n_prep_reg;
    logic [RW-1:0] d_prep_reg;
    logic          neg_prep_reg;

    logic [RW-1:0]    rem_reg [OUT_W+1];
    logic [RW-1:0]    d_reg   [OUT_W+1];
    logic [OUT_W-1:0] q_reg   [OUT_W+1];
    logic             neg_reg [OUT_W+1];
    logic             ovf_reg [OUT_W+1];

    logic signed [OUT_W-1:0] quo_reg;
    logic                    clip_reg;

    // Magnitudes; the most negative value maps to its unsigned magnitude.
    always_comb
    begin
        an = num[DW-1] ? DW'(-num) : DW'(num);
        ad = den[DW-1] ? DW'(-den) : DW'(den);
    end

    // Rounded dividend 32*|num| + |den| over divisor 2*|den|.
    always_ff @(posedge clk)
    begin
        n_prep_reg   <= (RW'(an) << (FRAC_W + 1)) + RW'(ad);
        d_prep_reg   <= RW'(ad) << 1;
        neg_prep_reg <= num[DW-1] ^ den[DW-1];
    end

    // Quotients that need more than OUT_W bits overflow in any case.
    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= n_prep_reg >= (d_prep_reg << OUT_W);
        rem_reg[0] <= n_prep_reg;
        d_reg[0]   <= d_prep_reg;
        neg_reg[0] <= neg_prep_reg;
        q_reg[0]   <= '0;
    end

    // One restoring division step per stage, most significant bit first.
    for (genvar s = 0; s < OUT_W; s++)
    begin : g_step
        localparam int SH = OUT_W - 1 - s;
        logic [RW-1:0] dsh;
        assign dsh = d_reg[s] << SH;

        always_ff @(posedge clk)
        begin
            if (rem_reg[s] >= dsh)
            begin
                rem_reg[s+1] <= rem_reg[s] - dsh;
                q_reg[s+1]   <= {q_reg[s][OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s+1] <= rem_reg[s];
                q_reg[s+1]   <= {q_reg[s][OUT_W-2:0], 1'b0};
            end
            d_reg[s+1]   <= d_reg[s];
            neg_reg[s+1] <= neg_reg[s];
            ovf_reg[s+1] <= ovf_reg[s];
        end
    end

    // Apply the sign and saturate.
    always_ff @(posedge clk)
    begin
        if (neg_reg[OUT_W])
        begin
            if (ovf_reg[OUT_W] || ({1'b0, q_reg[OUT_W]} > LIM))
            begin
                quo_reg  <= OUT_W'(-$signed(LIM));
                clip_reg <= 1'b1;
            end
            else
            begin
                quo_reg  <= -$signed(q_reg[OUT_W]);
                clip_reg <= 1'b0;
            end
        end
        else
        begin
            if (ovf_reg[OUT_W] || ({1'b0, q_reg[OUT_W]} > (LIM - 1'b1)))
            begin
                quo_reg  <= OUT_W'(LIM - 1'b1);
                clip_reg <= 1'b1;
            end
            else
            begin
                quo_reg  <= $signed(q_reg[OUT_W]);
                clip_reg <= 1'b0;
            end
        end
    end

    assign quo  = quo_reg;
    assign clip = clip_reg;

endmodule

/* src/two_view_point_triangulation_top.sv */
// Channel   Direction  Signals                                   Transfer when
// input     in         start, busy, left_col, left_row,          start && !busy
//                      right_col
// result    out        done, world_x, world_y, world_z,          done (one cycle)
//                      singular, clipped
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One item is taken every cycle; busy stays low.
// Each result follows its item through the input, coefficient, determinant,
// divider and result registers; the bit-per-stage divider has OUT_W + 3 stages.
// Reset clears the valid pipeline and the projection registers to zero.
// The receiver cannot stall, so the pipeline never holds.
module two_view_point_triangulation_top #(
    parameter int PIX_W  = tvpt_pkg::PIX_W_DEF,
    parameter int COEF_W = tvpt_pkg::COEF_W_DEF,
    parameter int OUT_W  = tvpt_pkg::OUT_W_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [PIX_W-1:0]              left_col,
    input  logic [PIX_W-1:0]              left_row,
    input  logic [PIX_W-1:0]              right_col,
    output logic                          done,
    output logic signed [OUT_W-1:0]       world_x,
    output logic signed [OUT_W-1:0]       world_y,
    output logic signed [OUT_W-1:0]       world_z,
    output logic                          singular,
    output logic                          clipped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tvpt_pkg::IDX_W-1:0]    cfg_index,
    input  logic [tvpt_pkg::REG_W-1:0]    cfg_data
);
    import tvpt_pkg::*;

    localparam int AW      = PIX_W + COEF_W + 1;
    localparam int DW      = 3 * AW + 3;
    localparam int DIV_LAT = OUT_W + 3;
    localparam int TOT     = 3 + DET_LAT + DIV_LAT;

    logic [REG_W-1:0] cfg_reg [NUM_REGS];

    logic [TOT-1:0]   valid_reg;
    logic [PIX_W-1:0] u_reg [3];

    logic signed [AW-1:0] ue  [3];
    logic signed [AW-1:0] cbe [3][4];
    logic signed [AW-1:0] cte [3][4];
    logic [REG_W-1:0]     top_row [3];
    logic [REG_W-1:0]     bot_row [3];

    logic signed [AW-1:0] a_reg [3][3];
    logic signed [AW-1:0] b_reg [3];

    logic signed [AW-1:0] mat [4][3][3];
    logic signed [DW-1:0] det [4];

    logic signed [OUT_W-1:0] quo  [3];
    logic                    clip [3];

    logic [DIV_LAT-1:0] sing_reg;

    logic signed [OUT_W-1:0] x_reg;
    logic signed [OUT_W-1:0] y_reg;
    logic signed [OUT_W-1:0] z_reg;
    logic                    singular_reg;
    logic                    clipped_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Projection register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CAM1_ROW0: cfg_reg[REG_CAM1_ROW0] <= cfg_data;
                REG_CAM1_ROW1: cfg_reg[REG_CAM1_ROW1] <= cfg_data;
                REG_CAM1_ROW2: cfg_reg[REG_CAM1_ROW2] <= cfg_data;
                REG_CAM2_ROW0: cfg_reg[REG_CAM2_ROW0] <= cfg_data;
                REG_CAM2_ROW2: cfg_reg[REG_CAM2_ROW2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[TOT-2:0], start && !busy};
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        u_reg[0] <= left_col;
        u_reg[1] <= left_row;
        u_reg[2] <= right_col;
    end

    // Unpack coefficients and widen pixel values.
    always_comb
    begin
        top_row[0] = cfg_reg[REG_CAM1_ROW0];
        bot_row[0] = cfg_reg[REG_CAM1_ROW2];
        top_row[1] = cfg_reg[REG_CAM1_ROW1];
        bot_row[1] = cfg_reg[REG_CAM1_ROW2];
        top_row[2] = cfg_reg[REG_CAM2_ROW0];
        bot_row[2] = cfg_reg[REG_CAM2_ROW2];
        for (int r = 0; r < 3; r++)
        begin
            ue[r] = AW'($signed({1'b0, u_reg[r]}));
            for (int j = 0; j < 4; j++)
            begin
                cbe[r][j] = AW'($signed(bot_row[r][j*COEF_W +: COEF_W]));
                cte[r][j] = AW'($signed(top_row[r][j*COEF_W +: COEF_W]));
            end
        end
    end

    // Linear system coefficients and right-hand side.
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                a_reg[r][c] <= ue[r] * cbe[r][c] - cte[r][c];
            end
            b_reg[r] <= cte[r][3] - ue[r] * cbe[r][3];
        end
    end

    // System matrix and the three Cramer matrices.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    mat[k][r][c] = ((k != 0) && (c == k - 1)) ? b_reg[r] : a_reg[r][c];
                end
            end
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_det
        tvpt_det3 #(
            .AW (AW)
        ) u_det (
            .clk (clk),
            .m   (mat[k]),
            .det (det[k])
        );
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        tvpt_div #(
            .DW    (DW),
            .OUT_W (OUT_W)
        ) u_div (
            .clk  (clk),
            .num  (det[k+1]),
            .den  (det[0]),
            .quo  (quo[k]),
            .clip (clip[k])
        );
    end

    // Singular flag delayed to meet the divider outputs.
    always_ff @(posedge clk)
    begin
        sing_reg <= {sing_reg[DIV_LAT-2:0], det[0] == '0};
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (sing_reg[DIV_LAT-1])
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            z_reg       <= '0;
            clipped_reg <= 1'b0;
        end
        else
        begin
            x_reg       <= quo[0];
            y_reg       <= quo[1];
            z_reg       <= quo[2];
            clipped_reg <= clip[0] | clip[1] | clip[2];
        end
        singular_reg <= sing_reg[DIV_LAT-1];
    end

    assign done     = valid_reg[TOT-1];
    assign world_x  = x_reg;
    assign world_y  = y_reg;
    assign world_z  = z_reg;
    assign singular = singular_reg;
    assign clipped  = clipped_reg;

    // Each result follows an accepted item that entered the valid pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOT))
        else $error("result without a matching item");

    // A singular system gives zero coordinates and no clip.
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (world_x == '0 && world_y == '0 && world_z == '0 && !clipped))
        else $error("singular result not zeroed");

    // A clipped result has at least one coordinate at a limit.
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |->
            (world_x == {1'b0, {(OUT_W-1){1'b1}}} || world_x == {1'b1, {(OUT_W-1){1'b0}}} ||
             world_y == {1'b0, {(OUT_W-1){1'b1}}} || world_y == {1'b1, {(OUT_W-1){1'b0}}} ||
             world_z == {1'b0, {(OUT_W-1){1'b1}}} || world_z == {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("clip flag without a saturated coordinate");

endmodule
